FILE: hdl/mlbpe_pkg.sv
// Package for the multi-LED blink pattern engine: mode codes, phase type,
// register indexes, field widths and reset values.
// No dependencies.
package mlbpe_pkg;

    // Field widths
    localparam int unsigned TimeW   = 16;
    localparam int unsigned CountW  = 16;
    localparam int unsigned ModeW   = 3;
    localparam int unsigned IndexW  = 3;
    localparam int unsigned PinsW   = 4;
    localparam int unsigned CfgIdxW = 2;

    // Default LED count
    localparam int unsigned NumLedsDefault = 4;

    // Mode codes; codes 5 to 7 are unknown and hold the LED
    localparam logic [ModeW-1:0] ModeOff         = 3'd0;
    localparam logic [ModeW-1:0] ModeOn          = 3'd1;
    localparam logic [ModeW-1:0] ModeBlinkInf    = 3'd2;
    localparam logic [ModeW-1:0] ModeBlinkRepeat = 3'd3;
    localparam logic [ModeW-1:0] ModeBlinkStop   = 3'd4;

    // Blink phase
    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_LIT   = 2'd1,
        PHASE_DARK  = 2'd2,
        PHASE_PAUSE = 2'd3
    } t_phase;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgOnTime    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgOffTime   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgPauseTime = 2'd2;

    // Register reset values
    localparam logic [TimeW-1:0] OnTimeReset    = 16'd100;
    localparam logic [TimeW-1:0] OffTimeReset   = 16'd100;
    localparam logic [TimeW-1:0] PauseTimeReset = 16'd1000;

    localparam logic [CountW-1:0] CountMax = '1;

endpackage

FILE: hdl/multi_led_blink_pattern_engine.sv
// The result is registered the cycle after its input is taken; one item per
// cycle unless the result side stalls. All LEDs advance in parallel lanes,
// each a 16-bit increment and compare between input and result register.
// Reset (synchronous, active low): LED 0 in mode on, others off, all idle,
// all pins dark, timing registers 100/100/1000, result channel empty.
//
// Top level of the multi-LED blink pattern engine.
// Depends on mlbpe_pkg.
module multi_led_blink_pattern_engine #(
    parameter int unsigned NUM_LEDS = mlbpe_pkg::NumLedsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] led_index, [5:3] new_mode, [21:6] blink_target, [23:22] zero
    input  logic [23:0]                   s_axis_tdata,
    // [0] kind (0 tick, 1 set mode)
    input  logic                          s_axis_tuser,
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] pin_levels, [7:4] zero
    output logic [7:0]                    m_axis_tdata,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [mlbpe_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [mlbpe_pkg::TimeW-1:0]   i_cfg_data
);

    localparam int unsigned TimeW  = mlbpe_pkg::TimeW;
    localparam int unsigned CountW = mlbpe_pkg::CountW;
    localparam int unsigned ModeW  = mlbpe_pkg::ModeW;
    localparam int unsigned PinsW  = mlbpe_pkg::PinsW;

    // Configuration registers
    logic [TimeW-1:0] r_on_time, r_off_time, r_pause_time;

    // Per-LED state
    logic [ModeW-1:0]     r_mode    [NUM_LEDS];
    logic [ModeW-1:0]     n_mode    [NUM_LEDS];
    mlbpe_pkg::t_phase    r_phase   [NUM_LEDS];
    mlbpe_pkg::t_phase    n_phase   [NUM_LEDS];
    logic [CountW-1:0]    r_done    [NUM_LEDS];
    logic [CountW-1:0]    n_done    [NUM_LEDS];
    logic [CountW-1:0]    r_goal    [NUM_LEDS];
    logic [CountW-1:0]    n_goal    [NUM_LEDS];
    logic [TimeW-1:0]     r_elapsed [NUM_LEDS];
    logic [TimeW-1:0]     n_elapsed [NUM_LEDS];
    logic [NUM_LEDS-1:0]  r_pin;
    logic [NUM_LEDS-1:0]  n_pin;

    // Result register
    logic             r_out_valid;
    logic [PinsW-1:0] r_out_pins;
    logic [PinsW-1:0] n_out_pins;

    logic                               in_xfer;
    logic                               in_kind;
    logic [mlbpe_pkg::IndexW-1:0]       in_index;
    logic [ModeW-1:0]                   in_mode;
    logic [CountW-1:0]                  in_target;

    assign in_kind   = s_axis_tuser;
    assign in_index  = s_axis_tdata[2:0];
    assign in_mode   = s_axis_tdata[5:3];
    assign in_target = s_axis_tdata[21:6];

    // Take a new transaction whenever the result slot is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time    <= mlbpe_pkg::OnTimeReset;
            r_off_time   <= mlbpe_pkg::OffTimeReset;
            r_pause_time <= mlbpe_pkg::PauseTimeReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mlbpe_pkg::CfgOnTime:    r_on_time    <= i_cfg_data;
                mlbpe_pkg::CfgOffTime:   r_off_time   <= i_cfg_data;
                mlbpe_pkg::CfgPauseTime: r_pause_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-LED lanes: set mode or advance by one tick
    always_comb begin
        logic [TimeW-1:0]  dur;
        logic [TimeW-1:0]  inc;
        logic              expired;
        logic [CountW-1:0] done_inc;
        dur      = '0;
        inc      = '0;
        expired  = 1'b0;
        done_inc = '0;
        n_pin    = r_pin;
        for (int i = 0; i < NUM_LEDS; i++) begin
            n_mode[i]    = r_mode[i];
            n_phase[i]   = r_phase[i];
            n_done[i]    = r_done[i];
            n_goal[i]    = r_goal[i];
            n_elapsed[i] = r_elapsed[i];

            // Shared saturating timer for whichever timed phase is active
            case (r_phase[i])
                mlbpe_pkg::PHASE_LIT:  dur = r_on_time;
                mlbpe_pkg::PHASE_DARK: dur = r_off_time;
                default:               dur = r_pause_time;
            endcase
            inc      = (r_elapsed[i] != mlbpe_pkg::CountMax) ?
                       r_elapsed[i] + TimeW'(1) : r_elapsed[i];
            expired  = (inc >= dur);
            done_inc = r_done[i] + CountW'(1);

            if (in_xfer && in_kind) begin
                // Set-mode item for this lane
                if (in_index == mlbpe_pkg::IndexW'(i)) begin
                    n_mode[i]  = in_mode;
                    n_phase[i] = mlbpe_pkg::PHASE_IDLE;
                    n_goal[i]  = in_target;
                end
            end else if (in_xfer) begin
                case (r_mode[i])
                    mlbpe_pkg::ModeOff: begin
                        n_pin[i]   = 1'b1;
                        n_phase[i] = mlbpe_pkg::PHASE_IDLE;
                    end
                    mlbpe_pkg::ModeOn: begin
                        n_pin[i]   = 1'b0;
                        n_phase[i] = mlbpe_pkg::PHASE_IDLE;
                    end
                    mlbpe_pkg::ModeBlinkInf,
                    mlbpe_pkg::ModeBlinkRepeat,
                    mlbpe_pkg::ModeBlinkStop: begin
                        if (r_phase[i] == mlbpe_pkg::PHASE_IDLE) begin
                            n_pin[i]     = 1'b0;
                            n_elapsed[i] = '0;
                            n_done[i]    = '0;
                            n_phase[i]   = mlbpe_pkg::PHASE_LIT;
                        end else begin
                            n_elapsed[i] = expired ? '0 : inc;
                            if (expired) begin
                                case (r_phase[i])
                                    mlbpe_pkg::PHASE_LIT: begin
                                        n_pin[i]   = 1'b1;
                                        n_phase[i] = mlbpe_pkg::PHASE_DARK;
                                    end
                                    mlbpe_pkg::PHASE_DARK: begin
                                        n_done[i] = done_inc;
                                        if (r_mode[i] != mlbpe_pkg::ModeBlinkInf &&
                                            done_inc >= r_goal[i]) begin
                                            if (r_mode[i] == mlbpe_pkg::ModeBlinkStop)
                                                n_mode[i] = mlbpe_pkg::ModeOff;
                                            else
                                                n_phase[i] = mlbpe_pkg::PHASE_PAUSE;
                                        end else begin
                                            n_pin[i]   = 1'b0;
                                            n_phase[i] = mlbpe_pkg::PHASE_LIT;
                                        end
                                    end
                                    default: begin
                                        // pause over: start a new run of blinks
                                        n_pin[i]   = 1'b0;
                                        n_done[i]  = '0;
                                        n_phase[i] = mlbpe_pkg::PHASE_LIT;
                                    end
                                endcase
                            end
                        end
                    end
                    default: ;  // unknown mode holds everything
                endcase
            end
        end
    end

    // Pin word: bits for LEDs beyond the count read dark; LEDs past the fourth are not in it
    always_comb begin
        n_out_pins = '1;
        for (int i = 0; i < PinsW; i++) begin
            if (i < NUM_LEDS)
                n_out_pins[i] = n_pin[i];
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_mode[i]    <= (i == 0) ? mlbpe_pkg::ModeOn : mlbpe_pkg::ModeOff;
                r_phase[i]   <= mlbpe_pkg::PHASE_IDLE;
                r_done[i]    <= '0;
                r_goal[i]    <= '0;
                r_elapsed[i] <= '0;
            end
            r_pin <= '1;
        end else begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_mode[i]    <= n_mode[i];
                r_phase[i]   <= n_phase[i];
                r_done[i]    <= n_done[i];
                r_goal[i]    <= n_goal[i];
                r_elapsed[i] <= n_elapsed[i];
            end
            r_pin <= n_pin;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_pins <= n_out_pins;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_pins};

`ifndef SYNTHESIS
    // An accepted transaction always leaves a result pending
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // A set-mode item never moves any pin
    a_set_holds_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && in_kind) |=> $stable(r_pin))
        else $error("set-mode item changed a pin");

    // A tick lights LED 0 when it is in mode on
    a_on_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !in_kind && r_mode[0] == mlbpe_pkg::ModeOn) |=> !r_pin[0])
        else $error("LED 0 in mode on is not lit after a tick");

    // The result's bit for LED 0 reflects the pin just computed
    a_result_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_pins[0] == r_pin[0])
        else $error("result pin word disagrees with LED 0 state");
`endif

endmodule

FILE: tb/multi_led_blink_pattern_engine_tb.sv
// Self-checking testbench for the multi-LED blink pattern engine: a directed
// table and random phases, each result checked against a predictor or table row.
// Depends on mlbpe_pkg and multi_led_blink_pattern_engine.
module multi_led_blink_pattern_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlbpe_pkg::*;

    localparam int unsigned NumLeds    = NumLedsDefault;
    localparam int          StallLimit = 500;
    localparam int          PhaseItems = 68;
    localparam int          NumPhases  = 8;

    // Item kinds carried on tuser
    localparam logic KindTick    = 1'b0;
    localparam logic KindSetMode = 1'b1;

    // Register index that maps to no register
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    // One row of stimulus: an item, or a register write (sel holds the index)
    typedef struct packed {
        logic              is_cfg;
        logic              kind;
        logic [IndexW-1:0] sel;
        logic [ModeW-1:0]  mode;
        logic [TimeW-1:0]  value;
        logic              typed;
        logic [PinsW-1:0]  pins;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // [2:0] led_index, [5:3] new_mode, [21:6] blink_target, [23:22] zero
    logic [23:0]         s_axis_tdata;
    // [0] kind (0 tick, 1 set mode)
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [3:0] pin_levels, [7:4] zero
    logic [7:0]          m_axis_tdata;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [TimeW-1:0]    i_cfg_data;

    // Predicted LED state
    logic [TimeW-1:0]  on_dur;
    logic [TimeW-1:0]  off_dur;
    logic [TimeW-1:0]  pause_dur;
    logic [ModeW-1:0]  mode_q    [NumLeds];
    t_phase            phase_q   [NumLeds];
    logic [CountW-1:0] done_cnt  [NumLeds];
    logic [CountW-1:0] goal_q    [NumLeds];
    logic [TimeW-1:0]  elapsed_q [NumLeds];
    logic              pin_q     [NumLeds];

    logic [PinsW-1:0] pins_due [$];
    t_stim_row        plan     [$];
    int               fail_count = 0;
    int               quiet_cycles;
    logic             src_idle;
    logic             snk_idle;

    multi_led_blink_pattern_engine #(
        .NUM_LEDS(NumLeds)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic void reset_leds();
        on_dur    = OnTimeReset;
        off_dur   = OffTimeReset;
        pause_dur = PauseTimeReset;
        for (int i = 0; i < NumLeds; i++) begin
            mode_q[i]    = (i == 0) ? ModeOn : ModeOff;
            phase_q[i]   = PHASE_IDLE;
            done_cnt[i]  = '0;
            goal_q[i]    = '0;
            elapsed_q[i] = '0;
            pin_q[i]     = 1'b1;
        end
    endfunction

    function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] data);
        case (idx)
            CfgOnTime:    on_dur = data;
            CfgOffTime:   off_dur = data;
            CfgPauseTime: pause_dur = data;
            default: ;
        endcase
    endfunction

    // Count one tick in the current timed phase; true when the phase is over
    function automatic logic lapse_done(int i, logic [TimeW-1:0] dur);
        if (elapsed_q[i] != CountMax)
            elapsed_q[i] = elapsed_q[i] + 1'b1;
        if (elapsed_q[i] >= dur) begin
            elapsed_q[i] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void tick_led(int i);
        logic [ModeW-1:0] m;
        m = mode_q[i];
        if (m == ModeOff) begin
            pin_q[i]   = 1'b1;
            phase_q[i] = PHASE_IDLE;
            return;
        end
        if (m == ModeOn) begin
            pin_q[i]   = 1'b0;
            phase_q[i] = PHASE_IDLE;
            return;
        end
        // unknown modes hold everything
        if (m != ModeBlinkInf && m != ModeBlinkRepeat && m != ModeBlinkStop)
            return;
        case (phase_q[i])
            PHASE_IDLE: begin
                pin_q[i]     = 1'b0;
                elapsed_q[i] = '0;
                done_cnt[i]  = '0;
                phase_q[i]   = PHASE_LIT;
            end
            PHASE_LIT: begin
                if (lapse_done(i, on_dur)) begin
                    pin_q[i]   = 1'b1;
                    phase_q[i] = PHASE_DARK;
                end
            end
            PHASE_DARK: begin
                if (lapse_done(i, off_dur)) begin
                    done_cnt[i] = done_cnt[i] + 1'b1;
                    if (m != ModeBlinkInf && done_cnt[i] >= goal_q[i]) begin
                        if (m == ModeBlinkStop)
                            mode_q[i] = ModeOff;
                        else
                            phase_q[i] = PHASE_PAUSE;
                    end else begin
                        pin_q[i]   = 1'b0;
                        phase_q[i] = PHASE_LIT;
                    end
                end
            end
            default: begin
                if (lapse_done(i, pause_dur)) begin
                    pin_q[i]    = 1'b0;
                    done_cnt[i] = '0;
                    phase_q[i]  = PHASE_LIT;
                end
            end
        endcase
    endfunction

    // Apply one item and return the pin word that it should produce
    function automatic logic [PinsW-1:0] predict_pins(logic kind, logic [IndexW-1:0] sel,
                                                      logic [ModeW-1:0] mode,
                                                      logic [CountW-1:0] target);
        logic [PinsW-1:0] w;
        if (kind == KindSetMode) begin
            if (sel < NumLeds) begin
                mode_q[sel]  = mode;
                phase_q[sel] = PHASE_IDLE;
                goal_q[sel]  = target;
            end
        end else begin
            for (int i = 0; i < NumLeds; i++)
                tick_led(i);
        end
        w = '1;
        for (int i = 0; i < NumLeds && i < PinsW; i++)
            if (!pin_q[i])
                w[i] = 1'b0;
        return w;
    endfunction

    // ---------------- stimulus rows ----------------

    function automatic t_stim_row mk_item(logic kind, logic [IndexW-1:0] sel,
                                          logic [ModeW-1:0] mode, logic [TimeW-1:0] value,
                                          logic typed, logic [PinsW-1:0] pins);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.kind   = kind;
        r.sel    = sel;
        r.mode   = mode;
        r.value  = value;
        r.typed  = typed;
        r.pins   = pins;
        return r;
    endfunction

    function automatic t_stim_row mk_cfg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] value);
        t_stim_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.sel    = {1'b0, idx};
        r.value  = value;
        return r;
    endfunction

    // Mostly short durations so blink cycles complete, some extremes
    function automatic logic [TimeW-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return TimeW'($urandom_range(5, 40));
            default: return TimeW'($urandom_range(1, 4));
        endcase
    endfunction

    // ---------------- drivers ----------------

    task automatic send_item(input t_stim_row r);
        int               gap;
        logic [PinsW-1:0] pins;
        gap = src_idle ? $urandom_range(0, 12) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.value, r.mode, r.sel};
        s_axis_tuser  <= r.kind;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pins = predict_pins(r.kind, r.sel, r.mode, r.value);
        pins_due.push_back(r.typed ? r.pins : pins);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stop sending and wait for every outstanding result, plus the pipe delay
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // ---------------- result side ----------------

    initial begin : result_sink
        int         gap;
        logic [7:0] want;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = snk_idle ? $urandom_range(0, 12) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (pins_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = {4'h0, pins_due.pop_front()};
                if (m_axis_tdata !== want) begin
                    $display("%0t: pin_levels mismatch, expected %b, actual %b",
                             $time, want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= StallLimit);
        $display("multi_led_blink_pattern_engine regression: fail");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin : main_seq
        logic [TimeW-1:0]  on_v;
        logic [TimeW-1:0]  off_v;
        logic [TimeW-1:0]  pause_v;
        logic              kind_v;
        logic [IndexW-1:0] sel_v;
        logic [ModeW-1:0]  mode_v;
        logic [CountW-1:0] val_v;

        src_idle      = 1'b1;
        snk_idle      = 1'b1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KindTick;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CfgOnTime;
        i_cfg_data    = '0;
        reset_leds();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bad indexes, pin hold on set mode, every mode,
        // zero goal, zero pause, ignored register, unknown modes
        plan.push_back(mk_item(KindSetMode, 3'd7, 3'd7, 16'hFFFF, 1'b1, 4'hF));
        plan.push_back(mk_item(KindTick, 3'd0, ModeOff, 16'h0000, 1'b1, 4'hE));
        plan.push_back(mk_item(KindSetMode, 3'd4, ModeOn, 16'h0000, 1'b1, 4'hE));
        plan.push_back(mk_item(KindSetMode, 3'd1, ModeOn, 16'h0000, 1'b1, 4'hE));
        plan.push_back(mk_item(KindTick, 3'd0, ModeOff, 16'h0000, 1'b1, 4'hC));
        plan.push_back(mk_cfg(CfgOnTime, 16'd1));
        plan.push_back(mk_cfg(CfgOffTime, 16'd2));
        plan.push_back(mk_cfg(CfgPauseTime, 16'd0));
        plan.push_back(mk_cfg(CfgUnused, 16'hFFFF));
        plan.push_back(mk_item(KindSetMode, 3'd0, ModeOff, 16'h0000, 1'b1, 4'hC));
        plan.push_back(mk_item(KindSetMode, 3'd1, ModeBlinkInf, 16'hFFFF, 1'b1, 4'hC));
        plan.push_back(mk_item(KindSetMode, 3'd2, ModeBlinkRepeat, 16'h0000, 1'b0, '0));
        plan.push_back(mk_item(KindSetMode, 3'd3, ModeBlinkStop, 16'd2, 1'b0, '0));
        // ticks carry junk in the unused fields
        for (int k = 0; k < 10; k++)
            plan.push_back(mk_item(KindTick, (k % 2) ? 3'd7 : 3'd0,
                                   (k % 2) ? 3'd7 : 3'd0,
                                   (k % 2) ? 16'hFFFF : 16'h0000, 1'b0, '0));
        plan.push_back(mk_item(KindSetMode, 3'd3, 3'd5, 16'h8000, 1'b0, '0));
        plan.push_back(mk_item(KindTick, 3'd0, ModeOff, 16'h0000, 1'b0, '0));
        plan.push_back(mk_item(KindTick, 3'd0, ModeOff, 16'h0000, 1'b0, '0));
        plan.push_back(mk_item(KindSetMode, 3'd2, 3'd6, 16'h5555, 1'b0, '0));
        plan.push_back(mk_item(KindTick, 3'd0, ModeOff, 16'h0000, 1'b0, '0));

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                settle();
                write_reg(plan[n].sel[CfgIdxW-1:0], plan[n].value);
            end else begin
                send_item(plan[n]);
            end
        end

        // Random phases, each with its own timing and idling pattern
        for (int ph = 0; ph < NumPhases; ph++) begin
            settle();
            case (ph)
                0: begin
                    on_v    = '1;
                    off_v   = '1;
                    pause_v = '1;
                end
                1: begin
                    on_v    = 16'd1;
                    off_v   = 16'd1;
                    pause_v = 16'd1;
                end
                2: begin
                    on_v    = '0;
                    off_v   = '0;
                    pause_v = '0;
                end
                default: begin
                    on_v    = pick_duration();
                    off_v   = pick_duration();
                    pause_v = pick_duration();
                end
            endcase
            write_reg(CfgOnTime, on_v);
            write_reg(CfgOffTime, off_v);
            write_reg(CfgPauseTime, pause_v);
            write_reg(CfgUnused, TimeW'($urandom));
            src_idle = ($urandom_range(0, 2) != 0);
            snk_idle = ($urandom_range(0, 2) != 0);

            repeat (PhaseItems) begin
                kind_v = ($urandom_range(0, 9) < 7) ? KindTick : KindSetMode;
                sel_v  = ($urandom_range(0, 7) == 0) ? IndexW'($urandom_range(4, 7))
                                                     : IndexW'($urandom_range(0, 3));
                mode_v = ($urandom_range(0, 9) == 0) ? ModeW'($urandom_range(5, 7))
                                                     : ModeW'($urandom_range(0, 4));
                case ($urandom_range(0, 9))
                    0:       val_v = '1;
                    1:       val_v = CountW'($urandom);
                    default: val_v = CountW'($urandom_range(0, 4));
                endcase
                send_item(mk_item(kind_v, sel_v, mode_v, val_v, 1'b0, '0));
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("multi_led_blink_pattern_engine regression: pass");
        else
            $display("multi_led_blink_pattern_engine regression: fail");
        $finish;
    end

endmodule

FILE: files.f
hdl/mlbpe_pkg.sv
hdl/multi_led_blink_pattern_engine.sv
tb/multi_led_blink_pattern_engine_tb.sv
